>>> rtl/nfsa_pkg.sv
package nfsa_pkg;

    // Pool geometry
    localparam int SLOTS   = 64;
    localparam int SLOT_IW = $clog2(SLOTS);

    // Widths of the transaction fields
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;

    // Request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL         = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;

    // Free map read port
    typedef struct packed {
        logic               pool;
        logic [SLOT_IW-1:0] idx;
    } t_map_rd;

    // Free map write port: set marks the slot free, clear marks it used
    typedef struct packed {
        logic               en;
        logic               pool;
        logic [SLOT_IW-1:0] idx;
        logic               set;
    } t_map_wr;

    // Finished result handed to the output stage
    typedef struct packed {
        logic                valid;
        logic [SLOT_W-1:0]   granted;
        logic [STATUS_W-1:0] status;
    } t_res;

endpackage

>>> rtl/next_fit_slot_allocator.sv
// Channel   Direction  Signals                       Contents
// request   in         i_s_tvalid/o_s_tready         tdata: slot_index; tuser: action, pool
// result    out        o_m_tvalid/i_m_tready         tdata: granted_slot, status
//
// Allocate examines k slots, k from 1 to 64: the free map has one bit read port
// and the sequencer examines one slot per cycle.
// Reset (i_rst_n low, synchronous) marks every slot of both pools free and sets
// the shared search pointer to slot 0. A stalled result sits in the output
// register while the next request is accepted; a second result waits in the
// sequencer until the output register empties.
module next_fit_slot_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [5:0] slot_index, [7:6] zero
    input  logic [1:0] i_s_tuser,   // [0] action, [1] pool
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [5:0] granted_slot, [7:6] status
);
    import nfsa_pkg::*;

    t_map_rd rd;
    t_map_wr wr;
    t_res    res;
    logic    rd_free;
    logic    res_ready;

    logic       r_out_valid;
    logic [7:0] r_out_data;

    nfsa_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .o_free  (rd_free),
        .i_wr    (wr)
    );

    nfsa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_tvalid),
        .o_req_ready  (o_s_tready),
        .i_action     (i_s_tuser[0]),
        .i_pool       (i_s_tuser[1]),
        .i_slot_index (i_s_tdata[SLOT_W-1:0]),
        .o_rd         (rd),
        .i_rd_free    (rd_free),
        .o_wr         (wr),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    // Output register takes a result when empty or being drained
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_data <= {res.status, res.granted};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> rtl/nfsa_map.sv
module nfsa_map (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nfsa_pkg::t_map_rd i_rd,
    output logic             o_free,
    input  nfsa_pkg::t_map_wr i_wr
);
    import nfsa_pkg::*;

    // One free bit per slot and pool, 1 = free
    logic [SLOTS-1:0] r_free [2];

    // Clear to all free on reset, then apply single-bit updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free[0] <= '1;
            r_free[1] <= '1;
        end else if (i_wr.en) begin
            r_free[i_wr.pool][i_wr.idx] <= i_wr.set;
        end
    end

    // Single bit read port used by the scan sequencer
    assign o_free = r_free[i_rd.pool][i_rd.idx];

endmodule

>>> rtl/nfsa_ctrl.sv
module nfsa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic                          i_action,
    input  logic                          i_pool,
    input  logic [nfsa_pkg::SLOT_W-1:0]   i_slot_index,
    output nfsa_pkg::t_map_rd             o_rd,
    input  logic                          i_rd_free,
    output nfsa_pkg::t_map_wr             o_wr,
    output nfsa_pkg::t_res                o_res,
    input  logic                          i_res_ready
);
    import nfsa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FREE = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    localparam logic [SLOT_IW-1:0] LAST_SLOT = SLOT_IW'(SLOTS - 1);

    logic [1:0]          r_state,   n_state;
    logic                r_pool,    n_pool;
    logic [SLOT_IW-1:0]  r_idx,     n_idx;
    logic                r_idx_ok,  n_idx_ok;
    logic [SLOT_IW-1:0]  r_ptr,     n_ptr;
    logic [SLOT_IW-1:0]  r_cur,     n_cur;
    logic [SLOT_IW-1:0]  r_cnt,     n_cnt;
    logic [SLOT_W-1:0]   r_granted, n_granted;
    logic [STATUS_W-1:0] r_status,  n_status;

    // Sequencer: one slot examined per cycle while scanning
    always_comb begin
        n_state   = r_state;
        n_pool    = r_pool;
        n_idx     = r_idx;
        n_idx_ok  = r_idx_ok;
        n_ptr     = r_ptr;
        n_cur     = r_cur;
        n_cnt     = r_cnt;
        n_granted = r_granted;
        n_status  = r_status;
        o_wr.en   = 1'b0;
        o_wr.pool = r_pool;
        o_wr.idx  = r_idx;
        o_wr.set  = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_pool   = i_pool;
                    n_idx    = SLOT_IW'(i_slot_index);
                    n_idx_ok = 32'(i_slot_index) < SLOTS;
                    n_cur    = r_ptr;
                    n_cnt    = '0;
                    n_state  = (i_action == ACT_FREE) ? S_FREE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_rd_free) begin
                    // Claim the slot and move the shared pointer onto it
                    o_wr.en   = 1'b1;
                    o_wr.idx  = r_cur;
                    o_wr.set  = 1'b0;
                    n_ptr     = r_cur;
                    n_granted = SLOT_W'(r_cur);
                    n_status  = ST_OK;
                    n_state   = S_PUSH;
                end else if (r_cnt == LAST_SLOT) begin
                    n_granted = '0;
                    n_status  = ST_FULL;
                    n_state   = S_PUSH;
                end else begin
                    n_cur = (r_cur == LAST_SLOT) ? '0 : r_cur + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FREE: begin
                n_granted = '0;
                if (!r_idx_ok || i_rd_free) begin
                    n_status = ST_ALREADY_FREE;
                end else begin
                    o_wr.en  = 1'b1;
                    n_status = ST_OK;
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
    end

    // Hold request operands and the pending result
    always_ff @(posedge i_clk) begin
        r_pool    <= n_pool;
        r_idx     <= n_idx;
        r_idx_ok  <= n_idx_ok;
        r_cur     <= n_cur;
        r_cnt     <= n_cnt;
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    assign o_req_ready = (r_state == S_IDLE);

    // Read the scanned slot, or the slot being freed
    assign o_rd.pool = r_pool;
    assign o_rd.idx  = (r_state == S_SCAN) ? r_cur : r_idx;

    assign o_res.valid   = (r_state == S_PUSH);
    assign o_res.granted = r_granted;
    assign o_res.status  = r_status;

endmodule

>>> test/nfsa_checker.sv
`timescale 1ns / 100ps

module nfsa_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [5:0] slot_index, [7:6] zero
    input  logic [1:0] i_s_tuser,   // [0] action, [1] pool
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [5:0] granted_slot, [7:6] status
    output int         o_fail_count,
    output int         o_pending
);

    import nfsa_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted;
        logic [STATUS_W-1:0] status;
    } t_slot_result;

    // Shadow allocator state: one free bit per slot and pool, shared pointer
    logic [SLOTS-1:0]   shadow_free [2];
    logic [SLOT_IW-1:0] shadow_ptr;

    t_slot_result results_due [$];
    int           mismatches = 0;

    // Work out the result of one request and advance the shadow state
    function automatic t_slot_result serve_request(input logic act, input logic pl,
                                                   input logic [SLOT_IW-1:0] idx);
        t_slot_result       res;
        logic [SLOT_IW-1:0] probe;
        logic               found;
        res.granted = '0;
        res.status  = ST_OK;
        found       = 1'b0;
        if (act == ACT_ALLOC) begin
            // Next fit: scan from the shared pointer, wrapping once round the pool
            probe = shadow_ptr;
            for (int n = 0; n < SLOTS; n++) begin
                if (!found && shadow_free[pl][probe]) begin
                    shadow_free[pl][probe] = 1'b0;
                    shadow_ptr             = probe;
                    res.granted            = probe;
                    found                  = 1'b1;
                end
                probe = probe + 1'b1;
            end
            if (!found)
                res.status = ST_FULL;
        end else begin
            // Double free leaves the map untouched; the pointer never moves on a free
            if (shadow_free[pl][idx])
                res.status = ST_ALREADY_FREE;
            else
                shadow_free[pl][idx] = 1'b1;
        end
        return res;
    endfunction

    // Retire results first, then queue the prediction for any new request
    always @(posedge i_clk) begin : watch_channels
        t_slot_result seen;
        t_slot_result want;
        if (!i_rst_n) begin
            shadow_free[0] = '1;
            shadow_free[1] = '1;
            shadow_ptr     = '0;
            results_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen.granted = i_m_tdata[SLOT_W-1:0];
                seen.status  = i_m_tdata[SLOT_W+STATUS_W-1:SLOT_W];
                if (results_due.size() == 0) begin
                    $display("%0t: result with nothing outstanding, got slot %0d status %0d",
                             $time, seen.granted, seen.status);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (seen.granted !== want.granted) begin
                        $display("%0t: granted slot expected %0d got %0d",
                                 $time, want.granted, seen.granted);
                        mismatches++;
                    end
                    if (seen.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, seen.status);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                results_due.push_back(serve_request(i_s_tuser[0], i_s_tuser[1],
                                                    i_s_tdata[SLOT_IW-1:0]));
        end
        o_fail_count <= mismatches;
        o_pending    <= results_due.size();
    end

endmodule

>>> test/tb_next_fit_slot_allocator.sv
`timescale 1ns / 100ps

module tb_next_fit_slot_allocator;

    import nfsa_pkg::*;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;   // [5:0] slot_index, [7:6] zero
    logic [1:0] s_tuser  = '0;   // [0] action, [1] pool
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [5:0] granted_slot, [7:6] status

    int fail_count;
    int pending;
    int requests_sent  = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    next_fit_slot_allocator u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    nfsa_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result channel at the rate of the current phase
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one request, idling first at the sender's rate, and hold until taken
    task automatic send_request(input logic act, input logic pl,
                                input logic [SLOT_IW-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, idx};
        s_tuser  <= {pl, act};
        do @(posedge clk); while (!s_tready);
        requests_sent++;
    endtask

    initial begin
        int phase_end;
        int burst_kind;
        int burst_len;
        logic burst_pool;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: frees of untouched slots, allocate ignoring the index,
        // pointer shared across pools, double free, no backtracking to freed slots
        send_request(ACT_FREE,  1'b0, 6'd0);
        send_request(ACT_FREE,  1'b1, 6'd63);
        send_request(ACT_ALLOC, 1'b0, 6'd63);
        send_request(ACT_ALLOC, 1'b0, 6'd42);
        send_request(ACT_ALLOC, 1'b1, 6'd0);
        send_request(ACT_FREE,  1'b0, 6'd0);
        send_request(ACT_FREE,  1'b0, 6'd0);
        send_request(ACT_ALLOC, 1'b0, 6'd21);
        send_request(ACT_FREE,  1'b1, 6'd1);
        send_request(ACT_FREE,  1'b1, 6'd63);
        send_request(ACT_ALLOC, 1'b1, 6'd63);
        send_request(ACT_FREE,  1'b0, 6'd2);
        send_request(ACT_FREE,  1'b0, 6'd1);
        send_request(ACT_FREE,  1'b1, 6'd2);
        send_request(ACT_ALLOC, 1'b1, 6'd0);
        send_request(ACT_FREE,  1'b1, 6'd63);

        // Random: fill bursts to drive pools to full, free bursts, mixed noise
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            phase_end = requests_sent + 225;
            while (requests_sent < phase_end) begin
                burst_kind = $urandom_range(9);
                burst_pool = 1'($urandom_range(1));
                if (burst_kind < 5) begin
                    burst_len = $urandom_range(72, 8);
                    repeat (burst_len)
                        send_request(ACT_ALLOC, burst_pool, SLOT_IW'($urandom_range(63)));
                end else if (burst_kind < 8) begin
                    burst_len = $urandom_range(40, 4);
                    repeat (burst_len)
                        send_request(ACT_FREE, burst_pool, SLOT_IW'($urandom_range(63)));
                end else begin
                    burst_len = $urandom_range(10, 1);
                    repeat (burst_len)
                        send_request(1'($urandom_range(1)), 1'($urandom_range(1)),
                                     SLOT_IW'($urandom_range(63)));
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for a full scan in flight
        @(posedge clk);
        wait (pending == 0);
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
